/* hdl/mamm_pkg.sv */
// Package for the moving average and min/max unit.
// Holds the fixed widths, the back-end state type and the status structs.
// No dependencies.
package mamm_pkg;

    localparam int CFG_BITS = 7;
    localparam int WIN_CALC_BITS = 8;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_SUM,
        BK_START,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* hdl/mamm_channels.sv */
// Handshake channels of the moving average and min/max unit.
// Sample, result and window-length configuration words; uses mamm_pkg.
interface mamm_sample_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mamm_result_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] last_value;
    logic signed [SAMPLE_BITS-1:0] window_mean;
    logic signed [SAMPLE_BITS-1:0] lowest_seen;
    logic signed [SAMPLE_BITS-1:0] highest_seen;

    modport source (output valid, output last_value, output window_mean,
                    output lowest_seen, output highest_seen, input ready);
    modport sink (input valid, input last_value, input window_mean,
                  input lowest_seen, input highest_seen, output ready);
endinterface

interface mamm_cfg_if import mamm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink (input valid, input window_length, output ready);
endinterface

/* hdl/moving_average_min_max_unit.sv */
// Top level of the moving average and min/max unit.
// Instantiates mamm_front, mamm_queue, mamm_back and mamm_divider; uses mamm_pkg.
//
// Channel   Direction  Payload
// samples   in         sample
// results   out        last_value, window_mean, lowest_seen, highest_seen
// cfg       in         window_length
//
// Each word passes through the read, sum, start, divide and done states of the back end;
// the divide state waits on the bit-serial divider, which produces one mean bit per cycle.
// Reset clears the window, the sum and the extremes and sets the window length to 8.
// A two-entry queue lets the front keep taking words while the back end works, and
// the result register lets the back end start the next word while a result waits.
module moving_average_min_max_unit import mamm_pkg::*; #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mamm_sample_if.sink   samples,
    mamm_result_if.source results,
    mamm_cfg_if.sink      cfg
);

    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
    localparam int DIV_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int ENTRY_BITS = 3 * SAMPLE_BITS;

    q_stat_t                    q_stat;
    div_stat_t                  div_stat;
    logic                       push;
    logic                       pop;
    logic [ENTRY_BITS-1:0]      push_data;
    logic [ENTRY_BITS-1:0]      pop_data;
    logic                       div_start;
    logic signed [SUM_BITS-1:0] div_dividend;
    logic [DIV_BITS-1:0]        div_divisor;
    logic [SAMPLE_BITS-1:0]     div_quotient;

    mamm_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_stat   (q_stat),
        .push     (push),
        .push_data(push_data)
    );

    mamm_queue #(
        .WIDTH(ENTRY_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .stat     (q_stat)
    );

    mamm_back #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .WINDOW_MAX (WINDOW_MAX),
        .SUM_BITS   (SUM_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .results     (results),
        .q_stat      (q_stat),
        .pop         (pop),
        .pop_data    (pop_data),
        .div_start   (div_start),
        .div_dividend(div_dividend),
        .div_divisor (div_divisor),
        .div_stat    (div_stat),
        .div_quotient(div_quotient)
    );

    mamm_divider #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .SUM_BITS   (SUM_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .stat    (div_stat),
        .quotient(div_quotient)
    );

`ifndef NO_ASSERTIONS
    a_extremes_bracket_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.lowest_seen <= 0) && (results.highest_seen >= 0))
        else $error("Extremes do not bracket zero.");

    a_last_within_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.lowest_seen <= results.last_value)
                       && (results.last_value <= results.highest_seen))
        else $error("Last word lies outside the running extremes.");

    a_divider_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> !div_stat.done)
        else $error("Divider signaled completion twice in a row.");
`endif

endmodule

/* hdl/mamm_queue.sv */
// Short queue between the front end and the back end.
// Depends on mamm_pkg for the depth and the status struct.
module mamm_queue import mamm_pkg::*; #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_stat_t          stat
);

    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]     slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* hdl/mamm_front.sv */
// Front end: accepts sample words and tracks the running minimum and maximum.
// Depends on mamm_pkg and mamm_sample_if; feeds mamm_queue.
module mamm_front import mamm_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mamm_sample_if.sink                samples,
    input  q_stat_t                    q_stat,
    output logic                       push,
    output logic [3*SAMPLE_BITS-1:0]   push_data
);

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;

    assign samples.ready = !q_stat.full;
    assign push          = samples.valid && samples.ready;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (push && (samples.sample < min_reg))
        begin
            min_next = samples.sample;
        end
        if (push && (samples.sample > max_reg))
        begin
            max_next = samples.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign push_data = {samples.sample, min_next, max_next};

endmodule

/* hdl/mamm_divider.sv */
// Bit-serial restoring divider for the window mean, one quotient bit a cycle.
// Depends on mamm_pkg for the status struct.
module mamm_divider import mamm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 23,
    parameter int DIV_BITS    = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]        divisor,
    output div_stat_t                  stat,
    output logic [SAMPLE_BITS-1:0]     quotient
);

    localparam int MAG_BITS = SUM_BITS - 1;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [MAG_BITS-1:0] quo_reg, quo_next;
    logic [DIV_BITS-1:0] dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [SUM_BITS-1:0] mag_full;
    logic [DIV_BITS:0]   rem_shift;
    logic [DIV_BITS:0]   rem_diff;
    logic [SAMPLE_BITS-1:0] quo_low;

    always_comb
    begin
        mag_full  = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
        rem_shift = {rem_reg, quo_reg[MAG_BITS-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(MAG_BITS);
            rem_next  = '0;
            quo_next  = mag_full[MAG_BITS-1:0];
            dvs_next  = divisor;
            neg_next  = dividend[SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_diff[DIV_BITS-1:0];
                quo_next = {quo_reg[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_BITS-1:0];
                quo_next = {quo_reg[MAG_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign quo_low    = quo_reg[SAMPLE_BITS-1:0];
    assign quotient   = neg_reg ? (~quo_low + 1'b1) : quo_low;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

/* hdl/mamm_back.sv */
// Back end: sample line memory, window sum, divider control and result register.
// Depends on mamm_pkg, mamm_cfg_if and mamm_result_if; drives mamm_divider.
module mamm_back import mamm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW_MAX  = 64,
    parameter int SUM_BITS    = 23,
    parameter int DIV_BITS    = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mamm_cfg_if.sink                   cfg,
    mamm_result_if.source              results,
    input  q_stat_t                    q_stat,
    output logic                       pop,
    input  logic [3*SAMPLE_BITS-1:0]   pop_data,
    output logic                       div_start,
    output logic signed [SUM_BITS-1:0] div_dividend,
    output logic [DIV_BITS-1:0]        div_divisor,
    input  div_stat_t                  div_stat,
    input  logic [SAMPLE_BITS-1:0]     div_quotient
);

    localparam int PTR_BITS = $clog2(WINDOW_MAX);

    back_state_t state_reg, state_next;

    logic [CFG_BITS-1:0]            win_reg;
    logic [PTR_BITS-1:0]            ptr_reg, ptr_next;
    logic                           wrapped_reg, wrapped_next;
    logic signed [SUM_BITS-1:0]     sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0]  cur_sample_reg, cur_min_reg, cur_max_reg;
    logic [SAMPLE_BITS-1:0]         mean_reg;
    logic [SAMPLE_BITS-1:0]         rd_data_reg;
    logic [SAMPLE_BITS-1:0]         line_mem [WINDOW_MAX];
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0]  out_last_reg, out_mean_reg, out_low_reg, out_high_reg;

    logic                           cfg_wr;
    logic                           mem_rd, mem_wr, sum_upd, out_load;
    logic [WIN_CALC_BITS-1:0]       win_ext, eff_full, last_full;
    logic [PTR_BITS-1:0]            last_idx;
    logic [SAMPLE_BITS-1:0]         oldest;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_comb
    begin
        win_ext = WIN_CALC_BITS'(win_reg);
        if (win_ext == '0)
        begin
            eff_full = WIN_CALC_BITS'(1);
        end
        else if (win_ext > WIN_CALC_BITS'(WINDOW_MAX))
        begin
            eff_full = WIN_CALC_BITS'(WINDOW_MAX);
        end
        else
        begin
            eff_full = win_ext;
        end
        last_full = eff_full - WIN_CALC_BITS'(1);
        last_idx  = last_full[PTR_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:  state_next = BK_SUM;
            BK_SUM:   state_next = BK_START;
            BK_START: state_next = BK_DIV;
            BK_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        sum_upd   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE:  pop = !q_stat.empty;
            BK_READ:  mem_rd = 1'b1;
            BK_SUM:
            begin
                mem_wr  = 1'b1;
                sum_upd = 1'b1;
            end
            BK_START: div_start = 1'b1;
            BK_DIV:   ;
            BK_DONE:  out_load = !out_valid_reg || results.ready;
            default:  ;
        endcase
    end

    always_comb
    begin
        oldest       = wrapped_reg ? rd_data_reg : '0;
        sum_next     = sum_reg;
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        if (cfg_wr)
        begin
            sum_next     = '0;
            ptr_next     = '0;
            wrapped_next = 1'b0;
        end
        else if (sum_upd)
        begin
            sum_next = sum_reg
                     - {{(SUM_BITS - SAMPLE_BITS){oldest[SAMPLE_BITS-1]}}, oldest}
                     + {{(SUM_BITS - SAMPLE_BITS){cur_sample_reg[SAMPLE_BITS-1]}},
                        cur_sample_reg};
            if (ptr_reg == last_idx)
            begin
                ptr_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            win_reg       <= WINDOW_RESET;
            ptr_reg       <= '0;
            wrapped_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr)
            begin
                win_reg <= cfg.window_length;
            end
            ptr_reg       <= ptr_next;
            wrapped_reg   <= wrapped_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            line_mem[ptr_reg] <= cur_sample_reg;
        end
        if (mem_rd)
        begin
            rd_data_reg <= line_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_sample_reg <= pop_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            cur_min_reg    <= pop_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
            cur_max_reg    <= pop_data[SAMPLE_BITS-1:0];
        end
        if (div_stat.done)
        begin
            mean_reg <= div_quotient;
        end
        if (out_load)
        begin
            out_last_reg <= cur_sample_reg;
            out_mean_reg <= mean_reg;
            out_low_reg  <= cur_min_reg;
            out_high_reg <= cur_max_reg;
        end
    end

    assign div_dividend         = sum_reg;
    assign div_divisor          = eff_full[DIV_BITS-1:0];
    assign results.valid        = out_valid_reg;
    assign results.last_value   = out_last_reg;
    assign results.window_mean  = out_mean_reg;
    assign results.lowest_seen  = out_low_reg;
    assign results.highest_seen = out_high_reg;

endmodule
